[design/clp_pkg.sv]
// Shared types, constants and helper functions of the ASCII command line parser.
package clp_pkg;

  // Default depth of the line store
  localparam int unsigned MaxLine = 64;

  // Character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChZero  = 8'h30;

  // Fraction handling: nine decimal digits; fr * 2^17 / 1e9 == fr * 2^8 / 5^9
  localparam logic [3:0]  FracDigits = 4'd9;
  // floor(2^40 / 5^9): reciprocal of 5^9 / 2^8 scaled by 2^32
  localparam logic [19:0] FracRecip  = 20'd562949;
  localparam logic [20:0] FracDiv    = 21'd1953125;
  // multiply, estimate, correct
  localparam logic [4:0]  FracSteps  = 5'd3;
  localparam logic [16:0] IntSat     = 17'd65536;

  // Output field widths
  localparam int unsigned DevW  = 8;
  localparam int unsigned CodeW = 4;
  localparam int unsigned ValW  = 32;
  localparam int unsigned OutW  = DevW + CodeW + ValW;
  localparam int unsigned OutTdataW = 48;

  typedef enum logic [3:0] {
    CmdTorque    = 4'd0,
    CmdVel       = 4'd1,
    CmdPos       = 4'd2,
    CmdMode      = 4'd3,
    CmdEn        = 4'd4,
    CmdDis       = 4'd5,
    CmdKp        = 4'd6,
    CmdKi        = 4'd7,
    CmdKd        = 4'd8,
    CmdGetAngle  = 4'd9,
    CmdGetVel    = 4'd10,
    CmdGetCur    = 4'd11,
    CmdGetStatus = 4'd12,
    CmdPing      = 4'd13,
    CmdAck       = 4'd14
  } cmd_code_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_SCAN2,
    S_PAD,
    S_FRAC,
    S_DONE
  } state_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_START1,
    OP_SCAN1,
    OP_START2,
    OP_SCAN2,
    OP_PAD,
    OP_FRAC_INIT,
    OP_FRAC,
    OP_LOAD
  } op_e;

  // Number scanner states
  typedef enum logic [1:0] {
    NS_BLANK,
    NS_INT,
    NS_FRAC,
    NS_STOP
  } num_state_e;

  typedef struct packed {
    logic term;
    logic fill_nz;
    logic scan_done;
    logic pad_done;
    logic frac_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic     ok;
    logic [3:0] code;
  } match_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChLf || c == ChCr;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Command name lookup; ch holds upcased chars, first char in the low byte
  function automatic match_t match_cmd(input logic [2:0] len, input logic [31:0] ch);
    match_t m;
    logic [7:0] c0, c1, c2, c3;
    c0 = ch[7:0];
    c1 = ch[15:8];
    c2 = ch[23:16];
    c3 = ch[31:24];
    m.ok = 1'b0;
    m.code = CmdTorque;
    case (len)
      3'd1: begin
        m.ok = 1'b1;
        if (c0 == "T") m.code = CmdTorque;
        else if (c0 == "V") m.code = CmdVel;
        else if (c0 == "P") m.code = CmdPos;
        else if (c0 == "M") m.code = CmdMode;
        else m.ok = 1'b0;
      end
      3'd2: begin
        m.ok = 1'b1;
        if (c0 == "E" && c1 == "N") m.code = CmdEn;
        else if (c0 == "K" && c1 == "P") m.code = CmdKp;
        else if (c0 == "K" && c1 == "I") m.code = CmdKi;
        else if (c0 == "K" && c1 == "D") m.code = CmdKd;
        else if (c0 == "?" && c1 == "A") m.code = CmdGetAngle;
        else if (c0 == "?" && c1 == "V") m.code = CmdGetVel;
        else if (c0 == "?" && c1 == "I") m.code = CmdGetCur;
        else if (c0 == "?" && c1 == "S") m.code = CmdGetStatus;
        else m.ok = 1'b0;
      end
      3'd3: begin
        m.ok = 1'b1;
        if (c0 == "D" && c1 == "I" && c2 == "S") m.code = CmdDis;
        else if (c0 == "A" && c1 == "C" && c2 == "K") m.code = CmdAck;
        else m.ok = 1'b0;
      end
      3'd4: begin
        m.ok = (c0 == "P" && c1 == "I" && c2 == "N" && c3 == "G");
        m.code = CmdPing;
      end
      default: m.ok = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[design/clp_ctrl.sv]
// Controller state machine of the ASCII command line parser.
module clp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  clp_pkg::status_t  status_i,
  output logic              in_ready_o,
  output clp_pkg::op_e      op_o
);

  clp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clp_pkg::S_IDLE: begin
        if (in_valid_i && status_i.term && status_i.fill_nz) state_d = clp_pkg::S_SCAN1;
      end
      clp_pkg::S_SCAN1: begin
        if (status_i.scan_done) state_d = clp_pkg::S_SCAN2;
      end
      clp_pkg::S_SCAN2: begin
        if (status_i.scan_done) state_d = clp_pkg::S_PAD;
      end
      clp_pkg::S_PAD: begin
        if (status_i.pad_done) state_d = clp_pkg::S_FRAC;
      end
      clp_pkg::S_FRAC: begin
        if (status_i.frac_done) state_d = clp_pkg::S_DONE;
      end
      clp_pkg::S_DONE: begin
        if (status_i.out_free) state_d = clp_pkg::S_IDLE;
      end
      default: state_d = clp_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    op_o = clp_pkg::OP_NONE;
    unique case (state_q)
      clp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!status_i.term) op_o = clp_pkg::OP_STORE;
          else if (status_i.fill_nz) op_o = clp_pkg::OP_START1;
        end
      end
      clp_pkg::S_SCAN1: begin
        op_o = status_i.scan_done ? clp_pkg::OP_START2 : clp_pkg::OP_SCAN1;
      end
      clp_pkg::S_SCAN2: begin
        op_o = clp_pkg::OP_SCAN2;
      end
      clp_pkg::S_PAD: begin
        op_o = status_i.pad_done ? clp_pkg::OP_FRAC_INIT : clp_pkg::OP_PAD;
      end
      clp_pkg::S_FRAC: begin
        op_o = status_i.frac_done ? clp_pkg::OP_NONE : clp_pkg::OP_FRAC;
      end
      clp_pkg::S_DONE: begin
        if (status_i.out_free) op_o = clp_pkg::OP_LOAD;
      end
      default: op_o = clp_pkg::OP_NONE;
    endcase
  end

endmodule

[design/clp_dp.sv]
// Datapath of the ASCII command line parser: line store, scanners, fraction unit, output register.
module clp_dp #(
  parameter int unsigned MAX_LINE = clp_pkg::MaxLine
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  clp_pkg::op_e                op_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        out_ready_i,
  output clp_pkg::status_t            status_o,
  output logic                        out_valid_o,
  output logic [clp_pkg::OutW-1:0]    out_data_o
);

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam logic [AW-1:0] FillMax = AW'(MAX_LINE - 1);

  logic [7:0] mem [MAX_LINE];

  // Store and read pointer state
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] lim_q, lim_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] idx_q;
  logic          issue_q, issue_d;
  logic          vld_q;
  logic [7:0]    rd_q;

  // First pass results
  logic [AW-1:0] len_q, len_d;
  logic          zero_q, zero_d;
  logic          colon_q, colon_d;

  // Second pass state
  logic [2:0]    tok_q, tok_d;
  logic          in_tok_q, in_tok_d;
  clp_pkg::num_state_e ns_q, ns_d;
  logic          neg_q, neg_d;
  logic [7:0]    id_q, id_d;
  logic [7:0]    dev_q, dev_d;
  logic [16:0]   ip_q, ip_d;
  logic [29:0]   fr_q, fr_d;
  logic [3:0]    k_q, k_d;
  logic [31:0]   cch_q, cch_d;
  logic [2:0]    clen_q, clen_d;
  logic          sh_ok_q, sh_ok_d;
  logic [3:0]    sh_code_q, sh_code_d;

  // Fraction unit
  logic [48:0]   prod_q, prod_d;
  logic [16:0]   qe_q, qe_d;
  logic [38:0]   chk_q, chk_d;
  logic [16:0]   fq_q, fq_d;
  logic [4:0]    fc_q, fc_d;

  // Output register
  logic                     out_vld_q, out_vld_d;
  logic [clp_pkg::OutW-1:0] out_q, out_d;

  logic          mem_we;
  logic          term;
  logic          last;

  assign term = rx_byte_i == clp_pkg::ChLf || rx_byte_i == clp_pkg::ChCr;
  assign last = ({1'b0, rp_q} + 1'b1) == {1'b0, lim_q};
  assign mem_we = op_i == clp_pkg::OP_STORE && fill_q != FillMax;

  // Line store: written at the fill count, read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[fill_q] <= rx_byte_i;
    if (issue_q) rd_q <= mem[rp_q];
    idx_q <= rp_q;
  end

  // Fill count, scan pointer and first pass
  always_comb begin
    fill_d = fill_q;
    lim_d = lim_q;
    rp_d = rp_q;
    issue_d = issue_q;
    len_d = len_q;
    zero_d = zero_q;
    colon_d = colon_q;
    if (issue_q) begin
      rp_d = rp_q + 1'b1;
      issue_d = !last;
    end
    unique case (op_i)
      clp_pkg::OP_STORE: begin
        fill_d = (fill_q != FillMax) ? fill_q + 1'b1 : '0;
      end
      clp_pkg::OP_START1: begin
        lim_d = fill_q;
        rp_d = '0;
        issue_d = fill_q != '0;
        len_d = fill_q;
        zero_d = 1'b0;
        colon_d = 1'b0;
        fill_d = '0;
      end
      clp_pkg::OP_SCAN1: begin
        if (vld_q && !zero_q) begin
          if (rd_q == 8'd0) begin
            len_d = idx_q;
            zero_d = 1'b1;
          end else if (rd_q == clp_pkg::ChColon) begin
            colon_d = 1'b1;
          end
        end
      end
      clp_pkg::OP_START2: begin
        lim_d = len_q;
        rp_d = '0;
        issue_d = len_q != '0;
      end
      default: ;
    endcase
  end

  // Second pass: tokens, command name and number scanning
  always_comb begin
    logic [7:0]          c;
    logic [7:0]          u;
    logic [3:0]          dig;
    logic                feed;
    logic                val_mode;
    logic                start;
    logic [2:0]          tnew;
    clp_pkg::num_state_e eff;
    logic [20:0]         ip_t;
    tok_d = tok_q;
    in_tok_d = in_tok_q;
    ns_d = ns_q;
    neg_d = neg_q;
    id_d = id_q;
    dev_d = dev_q;
    ip_d = ip_q;
    fr_d = fr_q;
    k_d = k_q;
    cch_d = cch_q;
    clen_d = clen_q;
    sh_ok_d = sh_ok_q;
    sh_code_d = sh_code_q;
    c = rd_q;
    u = clp_pkg::upcase(rd_q);
    dig = 4'(rd_q - clp_pkg::ChZero);
    feed = 1'b0;
    val_mode = 1'b1;
    start = 1'b0;
    tnew = tok_q;
    eff = ns_q;
    ip_t = ({4'b0, ip_q} << 3) + ({4'b0, ip_q} << 1) + 21'(dig);

    if (op_i == clp_pkg::OP_START2) begin
      tok_d = '0;
      in_tok_d = 1'b0;
      ns_d = clp_pkg::NS_STOP;
      neg_d = 1'b0;
      id_d = '0;
      dev_d = '0;
      ip_d = '0;
      fr_d = '0;
      k_d = '0;
      cch_d = '0;
      clen_d = '0;
      sh_ok_d = 1'b0;
      sh_code_d = clp_pkg::CmdTorque;
    end else if (op_i == clp_pkg::OP_PAD) begin
      if (k_q != clp_pkg::FracDigits) begin
        fr_d = (fr_q << 3) + (fr_q << 1);
        k_d = k_q + 1'b1;
      end
    end else if (op_i == clp_pkg::OP_SCAN2 && vld_q) begin
      if (!colon_q) begin
        // Shorthand: first letter picks the command, value follows
        if (idx_q == '0) begin
          sh_ok_d = 1'b1;
          case (u)
            "V": sh_code_d = clp_pkg::CmdVel;
            "P": sh_code_d = clp_pkg::CmdPos;
            "T": sh_code_d = clp_pkg::CmdTorque;
            "M": sh_code_d = clp_pkg::CmdMode;
            "E": sh_code_d = clp_pkg::CmdEn;
            "D": sh_code_d = clp_pkg::CmdDis;
            "A": sh_code_d = clp_pkg::CmdGetAngle;
            default: sh_ok_d = 1'b0;
          endcase
          ns_d = (sh_ok_d && u != "A") ? clp_pkg::NS_BLANK : clp_pkg::NS_STOP;
        end else begin
          feed = 1'b1;
        end
      end else begin
        // Colon form: id:cmd:value with empty tokens skipped
        if (c == clp_pkg::ChColon) begin
          in_tok_d = 1'b0;
        end else begin
          start = !in_tok_q;
          in_tok_d = 1'b1;
          if (start && tok_q != 3'd4) tnew = tok_q + 1'b1;
          tok_d = tnew;
          if (start && tnew == 3'd2) dev_d = neg_q ? 8'(8'd0 - id_q) : id_q;
          if (tnew == 3'd1 || tnew == 3'd3) begin
            feed = !(tnew == 3'd3 && !start && tok_q == 3'd4);
            val_mode = tnew == 3'd3;
            if (start) begin
              eff = clp_pkg::NS_BLANK;
              neg_d = 1'b0;
            end
          end
          if (tnew == 3'd2) begin
            if (clen_q < 3'd4) cch_d[clen_q[1:0]*8 +: 8] = u;
            if (clen_q != 3'd5) clen_d = clen_q + 1'b1;
          end
        end
      end
    end

    // Decimal number scanner
    if (feed) begin
      case (eff)
        clp_pkg::NS_BLANK: begin
          if (clp_pkg::is_blank(c)) begin
            ns_d = clp_pkg::NS_BLANK;
          end else if (c == clp_pkg::ChPlus || c == clp_pkg::ChMinus) begin
            neg_d = c == clp_pkg::ChMinus;
            ns_d = clp_pkg::NS_INT;
          end else if (clp_pkg::is_digit(c)) begin
            if (val_mode) ip_d = (ip_t > 21'(clp_pkg::IntSat)) ? clp_pkg::IntSat : ip_t[16:0];
            else id_d = (id_q << 3) + (id_q << 1) + 8'(dig);
            ns_d = clp_pkg::NS_INT;
          end else if (c == clp_pkg::ChDot && val_mode) begin
            ns_d = clp_pkg::NS_FRAC;
          end else begin
            ns_d = clp_pkg::NS_STOP;
          end
        end
        clp_pkg::NS_INT: begin
          if (clp_pkg::is_digit(c)) begin
            if (val_mode) ip_d = (ip_t > 21'(clp_pkg::IntSat)) ? clp_pkg::IntSat : ip_t[16:0];
            else id_d = (id_q << 3) + (id_q << 1) + 8'(dig);
            ns_d = clp_pkg::NS_INT;
          end else if (c == clp_pkg::ChDot && val_mode) begin
            ns_d = clp_pkg::NS_FRAC;
          end else begin
            ns_d = clp_pkg::NS_STOP;
          end
        end
        clp_pkg::NS_FRAC: begin
          if (clp_pkg::is_digit(c)) begin
            if (k_q != clp_pkg::FracDigits) begin
              fr_d = (fr_q << 3) + (fr_q << 1) + 30'(dig);
              k_d = k_q + 1'b1;
            end
            ns_d = clp_pkg::NS_FRAC;
          end else begin
            ns_d = clp_pkg::NS_STOP;
          end
        end
        default: ns_d = clp_pkg::NS_STOP;
      endcase
    end
  end

  // Fraction to 17 quotient bits, floor(fr * 2^8 / 5^9): reciprocal multiply
  // gives the quotient or one less, a compare against the next multiple fixes it
  always_comb begin
    prod_d = prod_q;
    qe_d = qe_q;
    chk_d = chk_q;
    fq_d = fq_q;
    fc_d = fc_q;
    if (op_i == clp_pkg::OP_FRAC_INIT) begin
      prod_d = 49'(fr_q) * 49'(clp_pkg::FracRecip);
      fq_d = '0;
      fc_d = '0;
    end else if (op_i == clp_pkg::OP_FRAC) begin
      case (fc_q)
        5'd0: qe_d = prod_q[48:32];
        5'd1: chk_d = 39'({1'b0, qe_q} + 18'd1) * 39'(clp_pkg::FracDiv);
        5'd2: fq_d = ({1'b0, fr_q, 8'b0} >= chk_q) ? qe_q + 17'd1 : qe_q;
        default: ;
      endcase
      fc_d = fc_q + 1'b1;
    end
  end

  // Result assembly and output register
  always_comb begin
    logic [16:0]  frac_r;
    logic [33:0]  mag;
    logic [31:0]  val;
    logic         ok;
    logic [3:0]   code;
    logic [7:0]   dev;
    clp_pkg::match_t m;
    frac_r = {1'b0, fq_q[16:1]} + 17'(fq_q[0]);
    mag = {1'b0, ip_q, 16'b0} + 34'(frac_r);
    if (neg_q) begin
      val = (mag > 34'h080000000) ? 32'h80000000 : 32'(32'd0 - mag[31:0]);
    end else begin
      val = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    m = clp_pkg::match_cmd(clen_q, cch_q);
    if (colon_q) begin
      ok = tok_q >= 3'd2 && m.ok;
      code = m.code;
      dev = dev_q;
    end else begin
      ok = sh_ok_q;
      code = sh_code_q;
      dev = 8'd1;
    end
    out_vld_d = out_vld_q && !out_ready_i;
    out_d = out_q;
    if (op_i == clp_pkg::OP_LOAD) begin
      out_vld_d = ok;
      out_d = {val, code, dev};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      issue_q <= 1'b0;
      vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      issue_q <= issue_d;
      vld_q <= issue_q;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    rp_q <= rp_d;
    len_q <= len_d;
    zero_q <= zero_d;
    colon_q <= colon_d;
    tok_q <= tok_d;
    in_tok_q <= in_tok_d;
    ns_q <= ns_d;
    neg_q <= neg_d;
    id_q <= id_d;
    dev_q <= dev_d;
    ip_q <= ip_d;
    fr_q <= fr_d;
    k_q <= k_d;
    cch_q <= cch_d;
    clen_q <= clen_d;
    sh_ok_q <= sh_ok_d;
    sh_code_q <= sh_code_d;
    prod_q <= prod_d;
    qe_q <= qe_d;
    chk_q <= chk_d;
    fq_q <= fq_d;
    fc_q <= fc_d;
    out_q <= out_d;
  end

  assign status_o.term = term;
  assign status_o.fill_nz = fill_q != '0;
  assign status_o.scan_done = !issue_q && !vld_q;
  assign status_o.pad_done = k_q == clp_pkg::FracDigits;
  assign status_o.frac_done = fc_q == clp_pkg::FracSteps;
  assign status_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

endmodule

[design/ascii_command_line_parser.sv]
// Top level of the ASCII command line parser.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata[7:0] rx_byte
// m_axis   out  tdata[7:0] device_id, [11:8] command_code, [43:12] value_q16
//
// Bytes are taken while the parser is idle. A terminator after a non-empty line
// starts two scans of the stored line through the registered line store read
// port, then fraction scaling and reciprocal scaling; no bytes are taken until
// the result is loaded into the output register. Reset empties the line and
// drops the output beat. A stalled output beat holds bytes off only once a line
// is done.
module ascii_command_line_parser #(
  parameter int unsigned MAX_LINE = clp_pkg::MaxLine
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [7:0] device_id, [11:8] command_code, [43:12] value_q16
);

  clp_pkg::status_t          status;
  clp_pkg::op_e              op;
  logic [clp_pkg::OutW-1:0]  out_data;

  clp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .op_o       (op)
  );

  clp_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .rx_byte_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {(clp_pkg::OutTdataW - clp_pkg::OutW)'(0), out_data};

endmodule

[sim/ascii_command_line_parser_checker.sv]
// Checker for the command line parser: line prediction and result comparison.
`timescale 1ns / 1ps
module ascii_command_line_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [7:0] device_id, [11:8] command_code, [43:12] value_q16
  output int          fail_cnt_o,
  output int          pending_o
);

  // Same layout as the result beat, last field in the low bits
  typedef struct packed {
    logic [31:0]        val;
    clp_pkg::cmd_code_e code;
    logic [7:0]         dev;
  } frame_t;

  logic [7:0] line_buf [clp_pkg::MaxLine];
  int unsigned line_len;
  frame_t frames_q [$];
  int fail_cnt;

  assign fail_cnt_o = fail_cnt;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic bit blank_ch(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Id: blanks, sign, digits modulo 256
  function automatic logic [7:0] id_of(input int unsigned p, input int unsigned n);
    logic [7:0] v;
    bit neg;
    v = 0;
    neg = 0;
    while (p < n && blank_ch(line_buf[p])) p++;
    if (p < n && (line_buf[p] == "+" || line_buf[p] == "-")) begin
      neg = line_buf[p] == "-";
      p++;
    end
    while (p < n && digit_ch(line_buf[p])) begin
      v = v * 8'd10 + (line_buf[p] - 8'd48);
      p++;
    end
    return neg ? 8'd0 - v : v;
  endfunction

  // Decimal to Q16.16, rounding half away, saturating
  function automatic logic [31:0] q16_of(input int unsigned p, input int unsigned n);
    logic [63:0] ip, fr, mag;
    int unsigned k;
    bit neg;
    ip = 0;
    fr = 0;
    k = 0;
    neg = 0;
    while (p < n && blank_ch(line_buf[p])) p++;
    if (p < n && (line_buf[p] == "+" || line_buf[p] == "-")) begin
      neg = line_buf[p] == "-";
      p++;
    end
    while (p < n && digit_ch(line_buf[p])) begin
      ip = ip * 10 + (line_buf[p] - 8'd48);
      if (ip > 65536) ip = 65536;
      p++;
    end
    if (p < n && line_buf[p] == ".") begin
      p++;
      while (p < n && digit_ch(line_buf[p])) begin
        if (k < 9) begin
          fr = fr * 10 + (line_buf[p] - 8'd48);
          k++;
        end
        p++;
      end
    end
    while (k < 9) begin
      fr = fr * 10;
      k++;
    end
    mag = ip * 65536 + (fr * 65536 + 64'd500000000) / 64'd1000000000;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Next non-empty colon-separated token
  function automatic bit token_at(input int unsigned p, input int unsigned n,
                                  output int unsigned s, output int unsigned e);
    s = 0;
    e = 0;
    while (p < n && line_buf[p] == ":") p++;
    if (p >= n) return 0;
    s = p;
    while (p < n && line_buf[p] != ":") p++;
    e = p;
    return 1;
  endfunction

  function automatic bit name_is(input int unsigned s, input int unsigned e, input string nm);
    if (e - s != nm.len()) return 0;
    for (int i = 0; i < nm.len(); i++)
      if (to_upper(line_buf[s + i]) != nm[i]) return 0;
    return 1;
  endfunction

  // Decode a finished line; pushes at most one expected frame
  task automatic decode_line();
    int unsigned n, s1, e1, s2, e2, s3, e3;
    bit has_colon, ok;
    frame_t f;
    string names [15];
    n = 0;
    has_colon = 0;
    ok = 1;
    names = '{"T", "V", "P", "M", "EN", "DIS", "KP", "KI", "KD",
              "?A", "?V", "?I", "?S", "PING", "ACK"};
    while (n < line_len && line_buf[n] != 8'h00) n++;
    for (int i = 0; i < n; i++) if (line_buf[i] == ":") has_colon = 1;
    if (!has_colon) begin
      if (n == 0) return;
      f.dev = 8'd1;
      f.val = 0;
      case (to_upper(line_buf[0]))
        "V": f.code = clp_pkg::CmdVel;
        "P": f.code = clp_pkg::CmdPos;
        "T": f.code = clp_pkg::CmdTorque;
        "M": f.code = clp_pkg::CmdMode;
        "E": f.code = clp_pkg::CmdEn;
        "D": f.code = clp_pkg::CmdDis;
        "A": f.code = clp_pkg::CmdGetAngle;
        default: ok = 0;
      endcase
      if (!ok) return;
      if (f.code != clp_pkg::CmdGetAngle && n > 1) f.val = q16_of(1, n);
      frames_q.push_back(f);
      return;
    end
    if (!token_at(0, n, s1, e1)) return;
    if (!token_at(e1, n, s2, e2)) return;
    ok = 0;
    // Names are listed in code order
    for (int i = 0; i < 15 && !ok; i++)
      if (name_is(s2, e2, names[i])) begin
        ok = 1;
        f.code = clp_pkg::cmd_code_e'(i);
      end
    if (!ok) return;
    f.dev = id_of(s1, n);
    f.val = token_at(e2, n, s3, e3) ? q16_of(s3, n) : 32'd0;
    frames_q.push_back(f);
  endtask

  // Byte beats feed the line model; result beats are compared
  always @(posedge clk_i or negedge rst_ni) begin
    frame_t got, want;
    if (!rst_ni) begin
      line_len = 0;
      fail_cnt = 0;
      frames_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[43:0];
        if (frames_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected frame dev=%0d cmd=%0d val=%h", $realtime,
                     got.dev, got.code, got.val);
        end else begin
          want = frames_q.pop_front();
          if (got != want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: frame mismatch exp dev=%0d cmd=%0d val=%h got dev=%0d cmd=%0d val=%h",
                       $realtime, want.dev, want.code, want.val, got.dev, got.code, got.val);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata == clp_pkg::ChLf || s_axis_tdata == clp_pkg::ChCr) begin
          if (line_len > 0) decode_line();
          line_len = 0;
        end else if (line_len < clp_pkg::MaxLine - 1) begin
          line_buf[line_len] = s_axis_tdata;
          line_len++;
        end else begin
          line_len = 0;
        end
      end
      pending_o = frames_q.size();
    end
  end

endmodule

[sim/ascii_command_line_parser_tb.sv]
// Testbench top for the command line parser: byte stimulus and verdict.
`timescale 1ns / 1ps
module ascii_command_line_parser_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [7:0] device_id, [11:8] command_code, [43:12] value_q16
  int          fail_cnt;
  int          pending;
  bit          calm;           // no idling on either side while set
  int          byte_cnt;

  ascii_command_line_parser u_top (.*);

  ascii_command_line_parser_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  // Send one byte, with a random gap before it; valid stays up between
  // back to back beats
  task automatic send_byte(input logic [7:0] b);
    if (!calm)
      while ($urandom_range(99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    byte_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input string s, input bit cr);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(cr ? clp_pkg::ChCr : clp_pkg::ChLf);
  endtask

  function automatic string rand_num();
    string s;
    int k;
    s = "";
    case ($urandom_range(5))
      0: s = "-";
      1: s = "+";
      2: s = " ";
      default: ;
    endcase
    k = $urandom_range(1, $urandom_range(3) == 0 ? 7 : 3);
    for (int i = 0; i < k; i++) s = {s, string'(8'd48 + 8'($urandom_range(9)))};
    if ($urandom_range(1)) begin
      s = {s, "."};
      k = $urandom_range(0, 11);
      for (int i = 0; i < k; i++) s = {s, string'(8'd48 + 8'($urandom_range(9)))};
    end
    return s;
  endfunction

  function automatic string rand_name();
    string nm [16];
    string s;
    nm = '{"T", "V", "P", "M", "EN", "DIS", "KP", "KI", "KD",
           "?A", "?V", "?I", "?S", "PING", "ACK", "XY"};
    s = nm[$urandom_range(15)];
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(1) && s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 8'd32;
    return s;
  endfunction

  // One random line: mostly well formed, some noise
  function automatic string rand_line();
    string s, lt;
    int k;
    lt = "VPTMEDAvptmedaXq";
    case ($urandom_range(9))
      0, 1, 2: s = {string'(lt[$urandom_range(15)]), rand_num()};
      3, 4, 5, 6: begin
        s = {rand_num(), ":", rand_name()};
        if ($urandom_range(3)) begin
          if ($urandom_range(3) == 0) s = {s, "::", rand_num()};
          else s = {s, ":", rand_num()};
        end
        if ($urandom_range(5) == 0) s = {s, ":7"};
        if ($urandom_range(5) == 0) s = {":", s};
      end
      default: begin
        s = "";
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          logic [7:0] b;
          b = 8'($urandom_range(255));
          if (b == clp_pkg::ChLf || b == clp_pkg::ChCr) b = ":";
          s = {s, string'(b)};
        end
      end
    endcase
    return s;
  endfunction

  initial begin
    string s;
    int waited;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    m_axis_tready = 0;
    calm = 0;
    byte_cnt = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: every command, extremes, overflow, zero byte, an empty line
    send_line("V1.5", 0);
    send_line("p-2.25", 1);
    send_line("t", 0);
    send_line("M3", 0);
    send_line("e", 0);
    send_line("D", 0);
    send_line("A123", 0);
    send_line("PING", 0);
    send_line("255:ping", 0);
    send_line("-1:?a:0.0000076", 0);
    send_line(" +300:Kp:99999.999999", 0);
    send_line("0:ki:-99999", 1);
    send_line("::7::kd:::-32768.00001:x", 0);
    send_line("2:dis", 0);
    send_line("3:ACK:32767.99999", 0);
    send_line("4:EN:0.5", 0);
    send_line("5:?V:", 0);
    send_line("6:?i:-0.000007629394", 0);
    send_line("7:?S", 0);
    send_line("8:bad:1", 0);
    send_line("9", 0);
    send_byte(clp_pkg::ChCr);
    // Zero byte inside a line cuts it short
    send_byte("V");
    send_byte("1");
    send_byte("2");
    send_byte(8'h00);
    send_byte("9");
    send_byte("9");
    send_byte(clp_pkg::ChLf);
    s = "V";
    for (int i = 0; i < 70; i++) s = {s, "9"};
    send_line(s, 0);
    s = "T";
    for (int i = 0; i < 62; i++) s = {s, "1"};
    send_line(s, 1);
    send_line({string'(8'hFF), string'(8'h80)}, 0);

    // Random lines; a calm stretch in the middle
    while (byte_cnt < 1400) begin
      calm = byte_cnt > 600 && byte_cnt < 800;
      send_line(rand_line(), $urandom_range(1));
    end
    calm = 0;
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/clp_pkg.sv
design/clp_ctrl.sv
design/clp_dp.sv
design/ascii_command_line_parser.sv
sim/ascii_command_line_parser_checker.sv
sim/ascii_command_line_parser_tb.sv
